>>> sv/ama_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive moving average package
// Field widths, fixed-point format, register codes and reset values shared
// by the adaptive moving average modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ama_pkg;

    localparam int PRICE_W        = 32;
    localparam int DIFF_W         = PRICE_W + 1;
    localparam int AVG_W          = 48;
    localparam int FRAC_W         = 16;
    localparam int SC_W           = 17;
    localparam int PERIOD_W       = 7;
    localparam int CFG_DATA_W     = SC_W;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_PERIOD_DEF = 64;

    localparam int MAG_W   = AVG_W + 1;
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = SC_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [SC_W-1:0] Q_ONE = SC_W'(1 << FRAC_W);

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_SC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SC = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RST  = 7'd10;
    localparam logic [SC_W-1:0]     FAST_SC_RST = 17'd43691;
    localparam logic [SC_W-1:0]     SLOW_SC_RST = 17'd4228;

endpackage

`default_nettype wire

>>> sv/ama_mul.sv
// ----------------------------------------------------------------------------
// Adaptive moving average shared multiplier
// Unsigned 25 x 17 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module ama_mul (
    input  wire logic                         clk,
    input  wire logic [ama_pkg::MUL_A_W-1:0]  a,
    input  wire logic [ama_pkg::MUL_B_W-1:0]  b,
    output logic      [ama_pkg::MUL_P_W-1:0]  prod
);
    import ama_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk) begin
        prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> sv/ama_hist.sv
// ----------------------------------------------------------------------------
// Adaptive moving average history memories
// Price ring (two read ports) and difference ring (one read port), both
// written once per beat, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ama_hist #(
    parameter int MAX_PERIOD = ama_pkg::MAX_PERIOD_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                we,
    input  wire logic [$clog2(MAX_PERIOD + 1)-1:0]   price_waddr,
    input  wire logic signed [ama_pkg::PRICE_W-1:0]  price_wdata,
    input  wire logic [$clog2(MAX_PERIOD + 1)-1:0]   prev_raddr,
    input  wire logic [$clog2(MAX_PERIOD + 1)-1:0]   back_raddr,
    output logic signed [ama_pkg::PRICE_W-1:0]       prev_rdata,
    output logic signed [ama_pkg::PRICE_W-1:0]       back_rdata,
    input  wire logic [$clog2(MAX_PERIOD)-1:0]       diff_waddr,
    input  wire logic [ama_pkg::DIFF_W-1:0]          diff_wdata,
    input  wire logic [$clog2(MAX_PERIOD)-1:0]       diff_raddr,
    output logic [ama_pkg::DIFF_W-1:0]               diff_rdata
);
    import ama_pkg::*;

    logic signed [PRICE_W-1:0] price_mem [MAX_PERIOD + 1];
    logic [DIFF_W-1:0]         diff_mem  [MAX_PERIOD];

    logic signed [PRICE_W-1:0] prev_rdata_reg;
    logic signed [PRICE_W-1:0] back_rdata_reg;
    logic [DIFF_W-1:0]         diff_rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            price_mem[price_waddr] <= price_wdata;
            diff_mem[diff_waddr]   <= diff_wdata;
        end
        prev_rdata_reg <= price_mem[prev_raddr];
        back_rdata_reg <= price_mem[back_raddr];
        diff_rdata_reg <= diff_mem[diff_raddr];
    end

    assign prev_rdata = prev_rdata_reg;
    assign back_rdata = back_rdata_reg;
    assign diff_rdata = diff_rdata_reg;

endmodule

`default_nettype wire

>>> sv/adaptive_moving_average.sv
// ----------------------------------------------------------------------------
// Adaptive moving average
// Kaufman adaptive moving average over signed integer prices, Q32.16 output.
// Each accepted beat yields one result beat. A full beat reads the history
// rings and updates the noise sum (ST_READ, ST_NOISE), runs the bit-serial
// efficiency-ratio divider (ST_DIV), and then passes through the one shared
// 25 x 17 multiplier (ratio blend, squaring, and the step in two partial
// products), plus load and idle. When the noise is zero the divider returns a
// zero ratio without iterating; warm-up beats skip the divider and multiplier.
// The result register lets the next beat in while the previous result waits
// on m_ready. Writing period restarts warm-up; configuration is to be written
// by the user only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_moving_average #(
    parameter int MAX_PERIOD = ama_pkg::MAX_PERIOD_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [ama_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [ama_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [ama_pkg::PRICE_W-1:0]   s_price,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [ama_pkg::AVG_W-1:0]          m_average,
    output logic                                      m_ready_res,
    output logic [ama_pkg::SC_W-1:0]                  m_efficiency
);
    import ama_pkg::*;

    localparam int PW    = $clog2(MAX_PERIOD + 1);
    localparam int DAW   = $clog2(MAX_PERIOD);
    localparam int NW    = DIFF_W + $clog2(MAX_PERIOD);
    localparam int CW    = (PW > PERIOD_W) ? PW : PERIOD_W;
    localparam int DCW   = $clog2(SC_W);
    localparam int SSC_W = 2 * FRAC_W + 2;
    localparam int TOT_W = MUL_P_W + MUL_A_W;
    localparam int HALF  = 1 << (FRAC_W - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_NOISE,
        ST_DIV,
        ST_MUL_ER,
        ST_SSC,
        ST_MUL_SQ,
        ST_SC2,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_STEP,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [PERIOD_W-1:0]        period_reg;
    logic [SC_W-1:0]            fast_sc_reg;
    logic [SC_W-1:0]            slow_sc_reg;
    logic [PW-1:0]              count_reg;
    logic [NW-1:0]              noise_reg;
    logic signed [AVG_W-1:0]    last_avg_reg;
    logic [PW-1:0]              price_pos_reg;
    logic [DAW-1:0]             diff_pos_reg;
    logic signed [PRICE_W-1:0]  price_reg;
    logic [DIFF_W-1:0]          d_reg;
    logic [DIFF_W-1:0]          signal_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic                       mag_neg_reg;
    logic [NW:0]                rem_reg;
    logic [SC_W-1:0]            q_reg;
    logic [DCW-1:0]             div_cnt_reg;
    logic [SC_W-1:0]            ssc_reg;
    logic [SC_W-1:0]            sc2_reg;
    logic [MUL_P_W-1:0]         acc_lo_reg;
    logic [MAG_W-1:0]           stepm_reg;
    logic signed [AVG_W-1:0]    avg_res_reg;
    logic                       rdy_res_reg;
    logic [SC_W-1:0]            eff_res_reg;
    logic                       m_valid_reg;
    logic signed [AVG_W-1:0]    m_average_reg;
    logic                       m_ready_res_reg;
    logic [SC_W-1:0]            m_efficiency_reg;

    logic [PW-1:0]              eff_period;
    logic [SC_W-1:0]            fs;
    logic [SC_W-1:0]            ss;
    logic                       sc_up;
    logic [SC_W-1:0]            sc_delta;
    logic [PW-1:0]              prev_addr;
    logic [PW-1:0]              back_addr;
    logic [PW:0]                back_wrap;
    logic [PW:0]                diff_pos_ext;
    logic [PW:0]                eff_ext;
    logic [PW:0]                old_diff_full;
    logic [DAW-1:0]             old_diff_addr;
    logic signed [PRICE_W-1:0]  prev_rd;
    logic signed [PRICE_W-1:0]  back_rd;
    logic [DIFF_W-1:0]          old_diff_rd;
    logic signed [DIFF_W-1:0]   dd_prev;
    logic signed [DIFF_W-1:0]   dd_back;
    logic [DIFF_W-1:0]          d_next;
    logic [DIFF_W-1:0]          signal_next;
    logic signed [AVG_W-1:0]    target;
    logic signed [MAG_W-1:0]    dm;
    logic [MAG_W-1:0]           mag_next;
    logic                       div_ge;
    logic [NW:0]                rem_after;
    logic [SSC_W-1:0]           ss_base;
    logic [SSC_W-1:0]           ssc32;
    logic [SSC_W-1:0]           ssc_rnd;
    logic [MUL_P_W-1:0]         sq_rnd;
    logic [TOT_W-1:0]           total;
    logic signed [AVG_W-1:0]    avg_step;
    logic                       hist_we;
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [MUL_P_W-1:0]         mul_p;

    always_comb begin
        if (period_reg == '0) begin
            eff_period = PW'(1);
        end else if (CW'(period_reg) > CW'(MAX_PERIOD)) begin
            eff_period = PW'(MAX_PERIOD);
        end else begin
            eff_period = PW'(period_reg);
        end
    end

    assign fs       = (fast_sc_reg > Q_ONE) ? Q_ONE : fast_sc_reg;
    assign ss       = (slow_sc_reg > Q_ONE) ? Q_ONE : slow_sc_reg;
    assign sc_up    = (fs >= ss);
    assign sc_delta = sc_up ? fs - ss : ss - fs;

    assign prev_addr = (price_pos_reg == '0) ? PW'(MAX_PERIOD) : price_pos_reg - PW'(1);
    assign back_wrap = {1'b0, price_pos_reg} + (PW + 1)'(MAX_PERIOD + 1) - {1'b0, eff_period};
    assign back_addr = (price_pos_reg >= eff_period) ? price_pos_reg - eff_period
                                                     : back_wrap[PW-1:0];

    assign diff_pos_ext  = (PW + 1)'(diff_pos_reg);
    assign eff_ext       = (PW + 1)'(eff_period);
    assign old_diff_full = (diff_pos_ext >= eff_ext)
                         ? diff_pos_ext - eff_ext
                         : diff_pos_ext + (PW + 1)'(MAX_PERIOD) - eff_ext;
    assign old_diff_addr = old_diff_full[DAW-1:0];

    assign hist_we = (state_reg == ST_READ);

    ama_hist #(
        .MAX_PERIOD (MAX_PERIOD)
    ) u_hist (
        .clk         (aclk),
        .we          (hist_we),
        .price_waddr (price_pos_reg),
        .price_wdata (price_reg),
        .prev_raddr  (prev_addr),
        .back_raddr  (back_addr),
        .prev_rdata  (prev_rd),
        .back_rdata  (back_rd),
        .diff_waddr  (diff_pos_reg),
        .diff_wdata  (d_next),
        .diff_raddr  (old_diff_addr),
        .diff_rdata  (old_diff_rd)
    );

    always_comb begin
        dd_prev     = DIFF_W'(price_reg) - DIFF_W'(prev_rd);
        dd_back     = DIFF_W'(price_reg) - DIFF_W'(back_rd);
        d_next      = (count_reg == '0) ? '0
                    : (dd_prev[DIFF_W-1] ? DIFF_W'(-dd_prev) : DIFF_W'(dd_prev));
        signal_next = dd_back[DIFF_W-1] ? DIFF_W'(-dd_back) : DIFF_W'(dd_back);
        target      = {price_reg, {FRAC_W{1'b0}}};
        dm          = MAG_W'(target) - MAG_W'(last_avg_reg);
        mag_next    = dm[MAG_W-1] ? MAG_W'(-dm) : MAG_W'(dm);
    end

    always_comb begin
        div_ge    = (rem_reg >= {1'b0, noise_reg});
        rem_after = div_ge ? rem_reg - {1'b0, noise_reg} : rem_reg;
    end

    always_comb begin
        ss_base  = SSC_W'({ss, {FRAC_W{1'b0}}});
        ssc32    = sc_up ? ss_base + SSC_W'(mul_p) : ss_base - SSC_W'(mul_p);
        ssc_rnd  = ssc32 + SSC_W'(HALF);
        sq_rnd   = mul_p + MUL_P_W'(HALF);
        total    = {mul_p, {MUL_A_W{1'b0}}} + TOT_W'(acc_lo_reg) + TOT_W'(HALF);
        avg_step = mag_neg_reg ? last_avg_reg - AVG_W'(stepm_reg)
                               : last_avg_reg + AVG_W'(stepm_reg);
    end

    always_comb begin
        case (state_reg)
            ST_MUL_ER: begin
                mul_a = MUL_A_W'(q_reg);
                mul_b = sc_delta;
            end
            ST_MUL_SQ: begin
                mul_a = MUL_A_W'(ssc_reg);
                mul_b = ssc_reg;
            end
            ST_MUL_LO: begin
                mul_a = mag_reg[MUL_A_W-1:0];
                mul_b = sc2_reg;
            end
            ST_MUL_HI: begin
                mul_a = MUL_A_W'(mag_reg[MAG_W-1:MUL_A_W]);
                mul_b = sc2_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ama_mul u_mul (
        .clk  (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            period_reg    <= PERIOD_RST;
            fast_sc_reg   <= FAST_SC_RST;
            slow_sc_reg   <= SLOW_SC_RST;
            count_reg     <= '0;
            noise_reg     <= '0;
            last_avg_reg  <= '0;
            price_pos_reg <= '0;
            diff_pos_reg  <= '0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        price_reg <= s_price;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    d_reg      <= d_next;
                    signal_reg <= signal_next;
                    if (count_reg >= eff_period) begin
                        noise_reg <= noise_reg - NW'(old_diff_rd);
                    end
                    price_pos_reg <= (price_pos_reg == PW'(MAX_PERIOD)) ? '0
                                                                       : price_pos_reg + PW'(1);
                    diff_pos_reg  <= (diff_pos_reg == DAW'(MAX_PERIOD - 1)) ? '0
                                                                           : diff_pos_reg + DAW'(1);
                    state_reg <= ST_NOISE;
                end
                ST_NOISE: begin
                    noise_reg   <= noise_reg + NW'(d_reg);
                    mag_reg     <= mag_next;
                    mag_neg_reg <= dm[MAG_W-1];
                    rem_reg     <= (NW + 1)'(signal_reg);
                    q_reg       <= '0;
                    div_cnt_reg <= '0;
                    eff_res_reg <= '0;
                    if ((PW + 1)'(count_reg) + (PW + 1)'(1) == (PW + 1)'(eff_period)) begin
                        avg_res_reg <= target;
                        rdy_res_reg <= 1'b1;
                        state_reg   <= ST_DONE;
                    end else if (count_reg < eff_period) begin
                        avg_res_reg <= '0;
                        rdy_res_reg <= 1'b0;
                        state_reg   <= ST_DONE;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (noise_reg == '0) begin
                        q_reg     <= '0;
                        state_reg <= ST_MUL_ER;
                    end else begin
                        rem_reg     <= {rem_after[NW-1:0], 1'b0};
                        q_reg       <= {q_reg[SC_W-2:0], div_ge};
                        div_cnt_reg <= div_cnt_reg + DCW'(1);
                        if (div_cnt_reg == DCW'(SC_W - 1)) begin
                            state_reg <= ST_MUL_ER;
                        end
                    end
                end
                ST_MUL_ER: begin
                    state_reg <= ST_SSC;
                end
                ST_SSC: begin
                    ssc_reg   <= ssc_rnd[FRAC_W +: SC_W];
                    state_reg <= ST_MUL_SQ;
                end
                ST_MUL_SQ: begin
                    state_reg <= ST_SC2;
                end
                ST_SC2: begin
                    sc2_reg   <= sq_rnd[FRAC_W +: SC_W];
                    state_reg <= ST_MUL_LO;
                end
                ST_MUL_LO: begin
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI: begin
                    acc_lo_reg <= mul_p;
                    state_reg  <= ST_ACC;
                end
                ST_ACC: begin
                    stepm_reg <= total[FRAC_W +: MAG_W];
                    state_reg <= ST_STEP;
                end
                ST_STEP: begin
                    avg_res_reg <= avg_step;
                    rdy_res_reg <= 1'b1;
                    eff_res_reg <= q_reg;
                    state_reg   <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg      <= 1'b1;
                        m_average_reg    <= avg_res_reg;
                        m_ready_res_reg  <= rdy_res_reg;
                        m_efficiency_reg <= eff_res_reg;
                        if (rdy_res_reg) begin
                            last_avg_reg <= avg_res_reg;
                        end
                        if (count_reg < eff_period) begin
                            count_reg <= count_reg + PW'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PERIOD: begin
                        period_reg   <= cfg_data[PERIOD_W-1:0];
                        count_reg    <= '0;
                        noise_reg    <= '0;
                        last_avg_reg <= '0;
                    end
                    CFG_FAST_SC: begin
                        fast_sc_reg <= cfg_data;
                    end
                    CFG_SLOW_SC: begin
                        slow_sc_reg <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_average    = m_average_reg;
    assign m_ready_res  = m_ready_res_reg;
    assign m_efficiency = m_efficiency_reg;

    a_eff_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_efficiency <= Q_ONE))
        else $error("efficiency above one");

    a_warmup_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready_res) |-> (m_average == '0 && m_efficiency == '0))
        else $error("nonzero result during warm-up");

    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= eff_period)
        else $error("sample count beyond period");

    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && noise_reg != '0) |-> (rem_reg < {noise_reg, 1'b0}))
        else $error("divider remainder out of range");

endmodule

`default_nettype wire
